@@ rtl/core/tbc_pkg.sv @@
// Package for the triangle barycentric coordinate block.
// Holds the result width, register indexes, lane codes and the operand map of the wide products.
// No dependencies.
package tbc_pkg;

  // Width of one result weight.
  localparam int OUT_W = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_VERTEX_ZERO = 2'd0;
  localparam logic [1:0] REG_VERTEX_ONE  = 2'd1;
  localparam logic [1:0] REG_VERTEX_TWO  = 2'd2;

  // Lanes of the divider row, one per weight.
  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_W = 2;
  localparam int NUM_LANES = 3;

  // Dot product slots.
  localparam int DOT_00 = 0;
  localparam int DOT_01 = 1;
  localparam int DOT_11 = 2;
  localparam int DOT_20 = 3;
  localparam int DOT_21 = 4;
  localparam int NUM_DOTS = 5;

  // Wide products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
  localparam int NUM_WPROD = 6;
  localparam int WP_A [NUM_WPROD] = '{DOT_00, DOT_01, DOT_11, DOT_01, DOT_00, DOT_01};
  localparam int WP_B [NUM_WPROD] = '{DOT_11, DOT_01, DOT_20, DOT_21, DOT_21, DOT_20};

  // Flags that travel with each item through the divider row.
  typedef struct packed {
    logic neg;
    logic ovf;
    logic degen;
  } tbc_flags_t;

endpackage

@@ rtl/core/tbc_div_cell.sv @@
// One step of the restoring divider row: produces one quotient bit.
// Depends on tbc_pkg for the flag struct.
module tbc_div_cell import tbc_pkg::*; #(
  parameter int DDW = 72,
  parameter int QW  = 24,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DDW-1:0]   rem_in,
  input  logic [QW-1:0]    low_in,
  input  logic [QW-1:0]    quo_in,
  input  logic [DDW-1:0]   div_in,
  input  tbc_flags_t       flg_in,
  output logic [DDW-1:0]   rem_out,
  output logic [QW-1:0]    low_out,
  output logic [QW-1:0]    quo_out,
  output logic [DDW-1:0]   div_out,
  output tbc_flags_t       flg_out
);

  logic [DDW:0] shifted;
  logic [DDW:0] diff;
  logic         take;

  // Bring in the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted = {rem_in, low_in[QW-1-IDX]};
    diff    = shifted - {1'b0, div_in};
    take    = (shifted >= {1'b0, div_in});
  end

  // Hand the partial remainder and quotient to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? diff[DDW-1:0] : shifted[DDW-1:0];
      quo_out <= {quo_in[QW-2:0], take};
      low_out <= low_in;
      div_out <= div_in;
      flg_out <= flg_in;
    end
  end

endmodule

@@ rtl/core/triangle_barycentric_coords.sv @@
// Usage notes:
// Three vertex registers are written through cfg_we / cfg_index / cfg_data
// while the block is idle; index 0, 1 and 2 select vertex zero, one and two,
// each packed z, y, x from the top, signed coordinates. Other indexes are
// ignored. Points enter on in_valid / in_stall; an item is taken at a clock
// edge with in_valid high and in_stall low. Each point gives one result of
// three saturated weights and a degenerate flag on out_valid / out_stall.
// Throughput is one item per cycle unless a held result stalls the pipeline.
// There are 33 register stages, the first loaded at the edge that takes the
// item: eight arithmetic stages (differences, small products, dot sums,
// split wide products, product merge, numerators, magnitudes, range check),
// then one restoring divider cell per result bit (24 cells, three lanes),
// then the saturating output register. All stages advance together; while
// the output register holds an item the receiver stalls, the whole pipeline
// holds and in_stall is raised. Synchronous reset clears every valid bit and
// the vertex registers to zero; no result is pending after reset.
// Depends on tbc_pkg and tbc_div_cell.
module triangle_barycentric_coords import tbc_pkg::*; #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [3*COORD_WIDTH-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_W-1:0]    weight_u,
  output logic signed [OUT_W-1:0]    weight_v,
  output logic signed [OUT_W-1:0]    weight_w,
  output logic                       degenerate
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int DW   = PW + 2;
  localparam int HB   = DW / 2;
  localparam int PLW  = DW + HB + 1;
  localparam int PHW  = 2 * DW - HB;
  localparam int DDW  = 2 * DW;
  localparam int NW   = DDW + 2;
  localparam int QW   = OUT_W;
  localparam int MW   = NW + WEIGHT_FRAC_BITS;
  localparam int HW   = MW - QW;
  localparam int CMW  = (HW > DDW) ? HW : DDW;
  localparam int FRONT = 8;

  localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [3*CW-1:0] vertex [3];
  logic            en;
  logic [FRONT-1:0] vld;

  // Whole pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Vertex registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex[0] <= '0;
      vertex[1] <= '0;
      vertex[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_ZERO: vertex[0] <= cfg_data;
        REG_VERTEX_ONE:  vertex[1] <= cfg_data;
        REG_VERTEX_TWO:  vertex[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT-2:0], in_valid};
    end
  end

  // Stage 1: edge vectors and point offset.
  logic signed [CW-1:0] pt [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] qv [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EW'($signed(vertex[1][k*CW +: CW])) - EW'($signed(vertex[0][k*CW +: CW]));
        e2[k] <= EW'($signed(vertex[2][k*CW +: CW])) - EW'($signed(vertex[0][k*CW +: CW]));
        qv[k] <= EW'(pt[k]) - EW'($signed(vertex[0][k*CW +: CW]));
      end
    end
  end

  // Stage 2: coordinate products.
  logic signed [PW-1:0] sp [NUM_DOTS][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sp[DOT_00][k] <= e1[k] * e1[k];
        sp[DOT_01][k] <= e1[k] * e2[k];
        sp[DOT_11][k] <= e2[k] * e2[k];
        sp[DOT_20][k] <= qv[k] * e1[k];
        sp[DOT_21][k] <= qv[k] * e2[k];
      end
    end
  end

  // Stage 3: dot products.
  logic signed [DW-1:0] dot [NUM_DOTS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_DOTS; j++) begin
        dot[j] <= DW'(sp[j][0]) + DW'(sp[j][1]) + DW'(sp[j][2]);
      end
    end
  end

  // Stage 4: wide products split into a low and a high partial product.
  logic signed [PLW-1:0] plo [NUM_WPROD];
  logic signed [PHW-1:0] phi [NUM_WPROD];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_WPROD; j++) begin
        plo[j] <= dot[WP_A[j]] * $signed({1'b0, dot[WP_B[j]][HB-1:0]});
        phi[j] <= dot[WP_A[j]] * $signed(dot[WP_B[j]][DW-1:HB]);
      end
    end
  end

  // Stage 5: merge the partial products.
  logic signed [DDW-1:0] wp [NUM_WPROD];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_WPROD; j++) begin
        wp[j] <= (DDW'(phi[j]) <<< HB) + DDW'(plo[j]);
      end
    end
  end

  // Stage 6: determinant and the numerators of v and w.
  logic signed [NW-1:0] det6, nv6, nw6;

  always_ff @(posedge clk) begin
    if (en) begin
      det6 <= NW'(wp[0]) - NW'(wp[1]);
      nv6  <= NW'(wp[2]) - NW'(wp[3]);
      nw6  <= NW'(wp[4]) - NW'(wp[5]);
    end
  end

  // Stage 7: numerator of u, magnitudes and signs.
  logic signed [NW-1:0] num6 [NUM_LANES];
  logic [NW-1:0]        mag7 [NUM_LANES];
  logic                 neg7 [NUM_LANES];
  logic [DDW-1:0]       div7;
  logic                 degen7;

  always_comb begin
    num6[LANE_U] = det6 - nv6 - nw6;
    num6[LANE_V] = nv6;
    num6[LANE_W] = nw6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        neg7[l] <= num6[l][NW-1];
        mag7[l] <= num6[l][NW-1] ? NW'(-num6[l]) : NW'(num6[l]);
      end
      div7   <= det6[DDW-1:0];
      degen7 <= (det6 == '0);
    end
  end

  // Stage 8: range check of the quotient and start of the division.
  logic [MW-1:0]   dvd7 [NUM_LANES];
  logic [CMW-1:0]  top7 [NUM_LANES];
  logic [DDW-1:0]  rem_c [NUM_LANES][QW+1];
  logic [QW-1:0]   low_c [NUM_LANES][QW+1];
  logic [QW-1:0]   quo_c [NUM_LANES][QW+1];
  logic [DDW-1:0]  div_c [NUM_LANES][QW+1];
  tbc_flags_t      flg_c [NUM_LANES][QW+1];
  logic [QW-1:0]   cvld;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dvd7[l] = {mag7[l], {WEIGHT_FRAC_BITS{1'b0}}};
      top7[l] = CMW'(dvd7[l][MW-1:QW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_c[l][0]       <= top7[l][DDW-1:0];
        low_c[l][0]       <= dvd7[l][QW-1:0];
        quo_c[l][0]       <= '0;
        div_c[l][0]       <= div7;
        flg_c[l][0].neg   <= neg7[l];
        flg_c[l][0].ovf   <= (top7[l] >= CMW'(div7));
        flg_c[l][0].degen <= degen7;
      end
    end
  end

  // Divider row: one quotient bit per cell, three lanes side by side.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    for (genvar c = 0; c < QW; c++) begin : g_cell
      tbc_div_cell #(.DDW(DDW), .QW(QW), .IDX(c)) u_cell (
        .clk     (clk),
        .en      (en),
        .rem_in  (rem_c[l][c]),
        .low_in  (low_c[l][c]),
        .quo_in  (quo_c[l][c]),
        .div_in  (div_c[l][c]),
        .flg_in  (flg_c[l][c]),
        .rem_out (rem_c[l][c+1]),
        .low_out (low_c[l][c+1]),
        .quo_out (quo_c[l][c+1]),
        .div_out (div_c[l][c+1]),
        .flg_out (flg_c[l][c+1])
      );
    end
  end

  // Valid bits that follow the divider row; bit c marks the output of cell c.
  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= '0;
    end else if (en) begin
      cvld <= {cvld[QW-2:0], vld[FRONT-1]};
    end
  end

  // Saturation of each finished quotient.
  logic [QW-1:0] wsat [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (flg_c[l][QW].degen) begin
        wsat[l] = '0;
      end else if (flg_c[l][QW].neg) begin
        if (flg_c[l][QW].ovf || (quo_c[l][QW] > SAT_NEG)) begin
          wsat[l] = SAT_NEG;
        end else begin
          wsat[l] = -quo_c[l][QW];
        end
      end else begin
        if (flg_c[l][QW].ovf || (quo_c[l][QW] > SAT_POS)) begin
          wsat[l] = SAT_POS;
        end else begin
          wsat[l] = quo_c[l][QW];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cvld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_u   <= $signed(wsat[LANE_U]);
      weight_v   <= $signed(wsat[LANE_V]);
      weight_w   <= $signed(wsat[LANE_W]);
      degenerate <= flg_c[LANE_U][QW].degen;
    end
  end

endmodule

@@ rtl/core/tbc_checker.sv @@
// Port-level checks for the triangle barycentric coordinate block.
// Depends on tbc_pkg; bound to triangle_barycentric_coords below.
module tbc_checker import tbc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] weight_u,
  input logic signed [OUT_W-1:0] weight_v,
  input logic signed [OUT_W-1:0] weight_w,
  input logic                    degenerate
);

  // A held result item keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight_u) && $stable(weight_v)
      && $stable(weight_w) && $stable(degenerate))
    else $error("stalled result item changed");

  // The input side only stalls while a result is held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A degenerate triangle gives zero weights.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> weight_u == '0 && weight_v == '0 && weight_w == '0)
    else $error("degenerate item with nonzero weight");

  // No result right after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind triangle_barycentric_coords tbc_checker u_tbc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .weight_u   (weight_u),
  .weight_v   (weight_v),
  .weight_w   (weight_w),
  .degenerate (degenerate)
);
